### design/assert_macros.svh
// Assertion helpers used by the counter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/dcc_pkg.sv
package dcc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_EXPERT_TOTAL = 3'd0,
		CFG_LAYER_TOTAL  = 3'd1,
		CFG_FIRST_LAYER  = 3'd2,
		CFG_DECAY        = 3'd3,
		CFG_SHIFT        = 3'd4
	} cfg_index_t;

	// Request function codes
	typedef enum logic [1:0] {
		FN_UPDATE = 2'd0,
		FN_QUERY  = 2'd1,
		FN_SHIFT  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	localparam int CFG_DATA_W = 17;
	localparam int SLOTS      = 8;

	// Q1.16 unity and rounding constant
	localparam logic [16:0] ONE_Q16   = 17'h1_0000;
	localparam logic [31:0] ROUND_Q16 = 32'h0000_8000;
	localparam logic [31:0] SAT_LIMIT = 32'hFFFF_FFFF - 32'h0001_0000;

	// Reset values of the configuration registers
	localparam logic [5:0]  EXPERT_TOTAL_RST = 6'd32;
	localparam logic [4:0]  LAYER_TOTAL_RST  = 5'd16;
	localparam logic [7:0]  FIRST_LAYER_RST  = 8'd0;
	localparam logic [16:0] DECAY_RST        = 17'd65208;
	localparam logic [16:0] SHIFT_RST        = 17'd32768;

	// Q1.16 product of two factors, rounded
	function automatic logic [16:0] q16_mul(input logic [16:0] a, input logic [16:0] b);
		logic [33:0] p;
		begin
			p = 34'(a) * 34'(b) + 34'(ROUND_Q16);
			return 17'(p >> 16);
		end
	endfunction

endpackage

### design/dcc_ifs.sv
// Request channel: one update, query or shift command per transfer
interface dcc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [31:0] tok_id;
	logic [7:0] layer_index;
	logic [3:0] expert_count;
	logic [7:0] expert_0;
	logic [7:0] expert_1;
	logic [7:0] expert_2;
	logic [7:0] expert_3;
	logic [7:0] expert_4;
	logic [7:0] expert_5;
	logic [7:0] expert_6;
	logic [7:0] expert_7;

	modport source (output valid, func, tok_id, layer_index, expert_count, expert_0,
		expert_1, expert_2, expert_3, expert_4, expert_5, expert_6, expert_7,
		input ready);
	modport sink (input valid, func, tok_id, layer_index, expert_count, expert_0,
		expert_1, expert_2, expert_3, expert_4, expert_5, expert_6, expert_7,
		output ready);
endinterface

// Response channel: one result per request
interface dcc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] weight_value;
	logic        layer_ok;

	modport source (output valid, weight_value, layer_ok, input ready);
	modport sink (input valid, weight_value, layer_ok, output ready);
endinterface

### design/decayed_coactivation_counter_unit.sv
// Expert co-activation counter with lazy exponential decay. The weights live in one
// single-port-read, single-port-write RAM of MAX_LAYERS*MAX_EXPERTS^2 words, and one
// request is worked on at a time by a sequencer. After reset the RAM is swept to zero,
// all MAX_LAYERS*MAX_EXPERTS^2 words, with req.ready low. The RAM port does one read
// and one write a cycle, and the decay power unit takes one exponent bit a cycle of
// the 32-bit token gap. A query raises the decay to the token gap, reads the cell,
// multiplies and rounds; an update to a stale layer raises the decay, sweeps the
// layer's MAX_EXPERTS^2 cells, then checks up to 28 slot pairs (at TOP_K = 8) and does
// two read-modify-writes per accepted pair. A shift sweeps all MAX_LAYERS*MAX_EXPERTS^2
// cells. Untracked updates, rejected queries and unused codes skip to the result.
// A finished result sits in an output register, so the next request is taken while
// it waits.
module decayed_coactivation_counter_unit #(
	parameter int MAX_EXPERTS = 32,
	parameter int MAX_LAYERS  = 16,
	parameter int TOP_K       = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [dcc_pkg::CFG_DATA_W-1:0]  cfg_data,
	dcc_req_if.sink                         req,
	dcc_rsp_if.source                       rsp
);
	import dcc_pkg::*;

	`include "assert_macros.svh"

	localparam int CELLS_PER_LAYER = MAX_EXPERTS * MAX_EXPERTS;
	localparam int CELL_TOTAL      = MAX_LAYERS * CELLS_PER_LAYER;
	localparam int AW              = $clog2(CELL_TOTAL);
	localparam int LW              = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POWER,
		ST_SWEEP,
		ST_PAIR_CHK,
		ST_PAIR_RD,
		ST_PAIR_WR,
		ST_Q_RD,
		ST_Q_MUL,
		ST_Q_FIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [5:0]  expert_total_q;
	logic [4:0]  layer_total_q;
	logic [7:0]  first_layer_q;
	logic [16:0] decay_q;
	logic [16:0] shift_q;

	// Token tracking and layer stamps
	logic [31:0] token_count_q;
	logic [31:0] prev_token_q;
	logic        seen_q;
	logic [31:0] stamp_q [MAX_LAYERS];

	// Latched request
	logic [1:0]  func_q;
	logic [3:0]  cnt_q;
	logic [7:0]  ex_q [SLOTS];
	logic [LW-1:0] slot_q;
	logic [AW-1:0] base_q;

	// Decay power unit
	logic [16:0] pw_res_q;
	logic [16:0] pw_base_q;
	logic [31:0] pw_gap_q;
	logic [16:0] factor_q;

	// Sweep pipeline
	logic [AW:0]   sw_idx_q;
	logic [AW:0]   sw_len_q;
	logic [AW-1:0] sw_base_q;
	logic          sw_v_s1;
	logic [AW-1:0] sw_addr_s1;
	logic          sw_v_s2;
	logic [AW-1:0] sw_addr_s2;
	logic [48:0]   prod_s2;

	// Pair scan
	logic [3:0] pi_q;
	logic [3:0] pj_q;
	logic       pdir_q;

	// Result
	logic [31:0] res_weight_q;
	logic        res_ok_q;
	logic        rsp_valid_q;
	logic [31:0] rsp_weight_q;
	logic        rsp_ok_q;

	// Clearing pass
	logic [AW:0] clr_idx_q;

	// Cell RAM
	logic [31:0]   cell_mem [CELL_TOTAL];
	logic [31:0]   rd_data_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;

	// Decode of the incoming request
	logic [8:0]  n_eff;
	logic [6:0]  lt_eff;
	logic [7:0]  layer_rel;
	logic        in_rng;
	logic [LW-1:0] slot_c;
	logic        tok_new;
	logic [31:0] tok_next;
	logic [31:0] gap_c;
	logic        accept;

	always_comb begin
		n_eff = (9'(expert_total_q) > 9'(MAX_EXPERTS)) ? 9'(MAX_EXPERTS) : 9'(expert_total_q);
		lt_eff = (7'(layer_total_q) > 7'(MAX_LAYERS)) ? 7'(MAX_LAYERS) : 7'(layer_total_q);
		layer_rel = req.layer_index - first_layer_q;
		in_rng = (req.layer_index >= first_layer_q) && (layer_rel < 8'(lt_eff));
		slot_c = layer_rel[LW-1:0];
		tok_new = (req.func == FN_UPDATE) && (!seen_q || (req.tok_id != prev_token_q));
		tok_next = token_count_q + 32'(tok_new);
		gap_c = tok_next - stamp_q[slot_c];
	end

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// Pair under the scan, sweep read enable, rounded product and saturating increment
	logic [7:0]  ex_a;
	logic [7:0]  ex_b;
	logic        pair_ok;
	logic [AW-1:0] pair_addr;
	logic        sw_rd_go;
	logic [48:0] sw_round;
	logic [31:0] scaled;
	logic [31:0] sat_inc;

	always_comb begin
		ex_a = ex_q[pi_q[2:0]];
		ex_b = ex_q[pj_q[2:0]];
		pair_ok = (9'(ex_a) < n_eff) && (9'(ex_b) < n_eff) && (ex_a != ex_b);
		if (pdir_q) begin
			pair_addr = AW'(base_q + AW'(ex_b) * AW'(MAX_EXPERTS) + AW'(ex_a));
		end else begin
			pair_addr = AW'(base_q + AW'(ex_a) * AW'(MAX_EXPERTS) + AW'(ex_b));
		end
		sw_rd_go = (state_q == ST_SWEEP) && (sw_idx_q != sw_len_q);
		sw_round = prod_s2 + 49'(ROUND_Q16);
		scaled = 32'(sw_round >> 16);
		sat_inc = (rd_data_q > SAT_LIMIT) ? 32'hFFFF_FFFF : rd_data_q + 32'(ONE_Q16);
	end

	// RAM port selection
	always_comb begin
		rd_en = 1'b0;
		rd_addr = pair_addr;
		if (sw_rd_go) begin
			rd_en = 1'b1;
			rd_addr = AW'(sw_base_q + sw_idx_q[AW-1:0]);
		end else if ((state_q == ST_PAIR_RD) || (state_q == ST_Q_RD)) begin
			rd_en = 1'b1;
		end
		wr_en = 1'b0;
		wr_addr = pair_addr;
		wr_data = sat_inc;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_idx_q[AW-1:0];
			wr_data = '0;
		end else if (sw_v_s2) begin
			wr_en = 1'b1;
			wr_addr = sw_addr_s2;
			wr_data = scaled;
		end else if (state_q == ST_PAIR_WR) begin
			wr_en = 1'b1;
		end
	end

	// Cell RAM, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cell_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= cell_mem[rd_addr];
		end
	end

	// Sweep pipeline payload: read address, then product (also the query product)
	always_ff @(posedge clk) begin
		sw_addr_s1 <= AW'(sw_base_q + sw_idx_q[AW-1:0]);
		sw_addr_s2 <= sw_addr_s1;
		if (sw_v_s1 || (state_q == ST_Q_MUL)) begin
			prod_s2 <= 49'(rd_data_q) * 49'(factor_q);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expert_total_q <= EXPERT_TOTAL_RST;
			layer_total_q <= LAYER_TOTAL_RST;
			first_layer_q <= FIRST_LAYER_RST;
			decay_q <= DECAY_RST;
			shift_q <= SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPERT_TOTAL: expert_total_q <= cfg_data[5:0];
				CFG_LAYER_TOTAL: layer_total_q <= cfg_data[4:0];
				CFG_FIRST_LAYER: first_layer_q <= cfg_data[7:0];
				CFG_DECAY: decay_q <= cfg_data;
				CFG_SHIFT: shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request payload latch
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			cnt_q <= (req.expert_count > 4'(TOP_K)) ? 4'(TOP_K) : req.expert_count;
			ex_q[0] <= req.expert_0;
			ex_q[1] <= req.expert_1;
			ex_q[2] <= req.expert_2;
			ex_q[3] <= req.expert_3;
			ex_q[4] <= req.expert_4;
			ex_q[5] <= req.expert_5;
			ex_q[6] <= req.expert_6;
			ex_q[7] <= req.expert_7;
			slot_q <= slot_c;
			base_q <= AW'(AW'(slot_c) * AW'(CELLS_PER_LAYER));
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			token_count_q <= '0;
			prev_token_q <= '0;
			seen_q <= 1'b0;
			for (int l = 0; l < MAX_LAYERS; l++) begin
				stamp_q[l] <= '0;
			end
			pw_res_q <= ONE_Q16;
			pw_base_q <= ONE_Q16;
			pw_gap_q <= '0;
			factor_q <= ONE_Q16;
			sw_idx_q <= '0;
			sw_len_q <= '0;
			sw_base_q <= '0;
			sw_v_s1 <= 1'b0;
			sw_v_s2 <= 1'b0;
			pi_q <= '0;
			pj_q <= '0;
			pdir_q <= 1'b0;
			res_weight_q <= '0;
			res_ok_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_weight_q <= '0;
			rsp_ok_q <= 1'b0;
		end else begin
			// output register drains independently of the sequencer
			if (rsp.ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			sw_v_s1 <= sw_rd_go;
			sw_v_s2 <= sw_v_s1;
			if (sw_rd_go) begin
				sw_idx_q <= sw_idx_q + 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == (AW+1)'(CELL_TOTAL - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_weight_q <= '0;
						// only tracked updates and queries report the layer
						res_ok_q <= in_rng && ((req.func == FN_UPDATE)
							|| (req.func == FN_QUERY));
						pi_q <= 4'd0;
						pj_q <= 4'd1;
						pdir_q <= 1'b0;
						pw_res_q <= ONE_Q16;
						pw_base_q <= (decay_q > ONE_Q16) ? ONE_Q16 : decay_q;
						pw_gap_q <= gap_c;
						sw_idx_q <= '0;
						if (tok_new) begin
							seen_q <= 1'b1;
							prev_token_q <= req.tok_id;
							token_count_q <= tok_next;
						end
						case (func_t'(req.func))
							FN_UPDATE: begin
								if (!in_rng) begin
									state_q <= ST_DONE;
								end else if (gap_c != '0) begin
									state_q <= ST_POWER;
								end else begin
									state_q <= ST_PAIR_CHK;
								end
							end
							FN_QUERY: begin
								if (in_rng && (9'(req.expert_0) < n_eff)
										&& (9'(req.expert_1) < n_eff)
										&& (req.expert_0 != req.expert_1)) begin
									state_q <= ST_POWER;
								end else begin
									state_q <= ST_DONE;
								end
							end
							FN_SHIFT: begin
								factor_q <= (shift_q > ONE_Q16) ? ONE_Q16 : shift_q;
								sw_base_q <= '0;
								sw_len_q <= (AW+1)'(CELL_TOTAL);
								state_q <= ST_SWEEP;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				// square-and-multiply, one gap bit per cycle
				ST_POWER: begin
					if (pw_gap_q == '0) begin
						factor_q <= pw_res_q;
						if (func_q == FN_QUERY) begin
							state_q <= ST_Q_RD;
						end else begin
							stamp_q[slot_q] <= token_count_q;
							sw_base_q <= base_q;
							sw_len_q <= (AW+1)'(CELLS_PER_LAYER);
							state_q <= ST_SWEEP;
						end
					end else begin
						if (pw_gap_q[0]) begin
							pw_res_q <= q16_mul(pw_res_q, pw_base_q);
						end
						pw_base_q <= q16_mul(pw_base_q, pw_base_q);
						pw_gap_q <= pw_gap_q >> 1;
					end
				end
				// wait for the last write to leave the pipeline
				ST_SWEEP: begin
					if (!sw_rd_go && !sw_v_s1 && !sw_v_s2) begin
						state_q <= (func_q == FN_UPDATE) ? ST_PAIR_CHK : ST_DONE;
					end
				end
				ST_PAIR_CHK: begin
					if (pj_q >= cnt_q) begin
						state_q <= ST_DONE;
					end else if (pair_ok) begin
						state_q <= ST_PAIR_RD;
					end else if (pj_q + 4'd1 < cnt_q) begin
						pj_q <= pj_q + 4'd1;
					end else begin
						pi_q <= pi_q + 4'd1;
						pj_q <= pi_q + 4'd2;
					end
				end
				ST_PAIR_RD: state_q <= ST_PAIR_WR;
				// each direction is its own read-modify-write, so repeats see prior writes
				ST_PAIR_WR: begin
					if (!pdir_q) begin
						pdir_q <= 1'b1;
						state_q <= ST_PAIR_RD;
					end else begin
						pdir_q <= 1'b0;
						state_q <= ST_PAIR_CHK;
						if (pj_q + 4'd1 < cnt_q) begin
							pj_q <= pj_q + 4'd1;
						end else begin
							pi_q <= pi_q + 4'd1;
							pj_q <= pi_q + 4'd2;
						end
					end
				end
				ST_Q_RD: state_q <= ST_Q_MUL;
				ST_Q_MUL: state_q <= ST_Q_FIN;
				ST_Q_FIN: begin
					res_weight_q <= scaled;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_weight_q <= res_weight_q;
						rsp_ok_q <= res_ok_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.weight_value = rsp_weight_q;
	assign rsp.layer_ok = rsp_ok_q;

	// Sweep writes only happen inside a sweep
	`ASSERT_IMPL(a_sweep_wr_in_sweep, clk, arst_n, sw_v_s2, state_q == ST_SWEEP,
		"sweep write outside sweep")
	// Every sweep read reaches the product stage next cycle
	`ASSERT_NEXT(a_sweep_pipe, clk, arst_n, sw_v_s1, sw_v_s2, "sweep pipeline lost a cell")
	// Power unit consumes one gap bit per step
	`ASSERT_NEXT(a_power_step, clk, arst_n, (state_q == ST_POWER) && (pw_gap_q != '0),
		pw_gap_q == ($past(pw_gap_q) >> 1), "decay power skipped a bit")
	// Only queries return a weight
	`ASSERT_IMPL(a_nonquery_zero, clk, arst_n, (state_q == ST_DONE) && (func_q != FN_QUERY),
		res_weight_q == '0, "non-query result carries a weight")

endmodule
